>>> rtl/eqj_pkg.sv
`timescale 1ns / 1ps

package eqj_pkg;

   localparam int KEY_W    = 64;
   localparam int INDEX_W  = 32;
   localparam int RIGHT_W  = 6;
   localparam int CNT_W    = 7;
   localparam int PROBE_W  = 32;

   localparam int RIGHT_ROWS_DEFAULT = 64;
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_BUILD  = 2'd1;
   localparam logic [1:0] KIND_PROBE  = 2'd2;
   localparam logic [1:0] KIND_REPORT = 2'd3;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_BUILD,
      OP_PROBE,
      OP_REPORT
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic signed [KEY_W-1:0]   key;
      logic                      has_key;
      logic [INDEX_W-1:0]        left_index;
   } req_type;

   typedef struct packed {
      logic                      is_report;
      logic [INDEX_W-1:0]        match_left;
      logic [RIGHT_W-1:0]        match_right;
      logic                      last;
      logic [CNT_W-1:0]          right_rows;
      logic [CNT_W-1:0]          distinct_keys;
      logic [PROBE_W-1:0]        probe_count;
      logic                      overflow;
   } rsp_type;

   typedef struct packed {
      op_type                    op;
      logic signed [KEY_W-1:0]   key;
      logic                      has_key;
      logic [INDEX_W-1:0]        left_index;
   } cmd_type;

   typedef struct packed {
      logic                      present;
      logic signed [KEY_W-1:0]   key;
   } entry_type;

endpackage

>>> rtl/eqj_fifo.sv
`timescale 1ns / 1ps

module eqj_fifo #(
   parameter int  DEPTH = eqj_pkg::CMD_DEPTH,
   parameter type DATA_TYPE = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  DATA_TYPE wdata,
   output logic     full,
   input  logic     pop,
   output DATA_TYPE rdata,
   output logic     empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   DATA_TYPE      slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a beat");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      empty |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("empty queue with pointers apart");

endmodule

>>> rtl/eqj_front.sv
`timescale 1ns / 1ps

module eqj_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  eqj_pkg::req_type req_data,
   output logic             req_full,
   input  logic             cmd_pop,
   output eqj_pkg::cmd_type cmd_data,
   output logic             cmd_empty
);

   eqj_pkg::cmd_type cmd_next;
   logic             keep;

   // A probe without a key has no effect at all, so it never reaches the back end.
   always_comb begin
      cmd_next.key        = req_data.key;
      cmd_next.has_key    = req_data.has_key;
      cmd_next.left_index = req_data.left_index;
      keep                = 1'b1;
      unique case (req_data.kind)
         eqj_pkg::KIND_CLEAR:  cmd_next.op = eqj_pkg::OP_CLEAR;
         eqj_pkg::KIND_BUILD:  cmd_next.op = eqj_pkg::OP_BUILD;
         eqj_pkg::KIND_PROBE: begin
            cmd_next.op = eqj_pkg::OP_PROBE;
            keep        = req_data.has_key;
         end
         default:              cmd_next.op = eqj_pkg::OP_REPORT;
      endcase
   end

   eqj_fifo #(
      .DEPTH     (eqj_pkg::CMD_DEPTH),
      .DATA_TYPE (eqj_pkg::cmd_type)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push && keep),
      .wdata (cmd_next),
      .full  (req_full),
      .pop   (cmd_pop),
      .rdata (cmd_data),
      .empty (cmd_empty)
   );

endmodule

>>> rtl/eqj_back.sv
`timescale 1ns / 1ps

module eqj_back #(
   parameter int RIGHT_ROWS = eqj_pkg::RIGHT_ROWS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  eqj_pkg::cmd_type cmd_data,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output eqj_pkg::rsp_type out_data,
   output logic             out_push,
   input  logic             out_full
);

   localparam int AW = (RIGHT_ROWS > 1) ? $clog2(RIGHT_ROWS) : 1;
   localparam int CW = eqj_pkg::CNT_W;
   localparam logic [CW-1:0] ROWS_MAX = CW'(RIGHT_ROWS);
   localparam logic [eqj_pkg::PROBE_W-1:0] PROBE_SAT = '1;

   eqj_pkg::state_type state_ff, state_in;
   eqj_pkg::cmd_type   cur_ff, cur_in;

   logic [CW-1:0]               rows_ff, rows_in;
   logic [CW-1:0]               distinct_ff, distinct_in;
   logic [eqj_pkg::PROBE_W-1:0] probes_ff, probes_in;
   logic                        dropped_ff, dropped_in;

   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          seen_ff, seen_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;

   eqj_pkg::entry_type mem [RIGHT_ROWS];
   eqj_pkg::entry_type rdata_ff;
   eqj_pkg::entry_type wentry;
   logic               mem_we, mem_re;

   logic is_probe, hit, advance, launch, scan_done;

   assign is_probe  = (cur_ff.op == eqj_pkg::OP_PROBE);
   assign hit       = cmp_valid_ff && rdata_ff.present && (rdata_ff.key == cur_ff.key);
   // A probe hit must push the held pair out before it can take its place.
   assign advance   = !(hit && is_probe && pend_valid_ff && out_full);
   assign launch    = (rd_idx_ff < rows_ff);
   assign scan_done = advance && !cmp_valid_ff && !launch;

   assign wentry.present = cur_ff.has_key;
   assign wentry.key     = cur_ff.key;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         eqj_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               if ((cmd_data.op == eqj_pkg::OP_BUILD && rows_ff < ROWS_MAX) ||
                   cmd_data.op == eqj_pkg::OP_PROBE) begin
                  state_in = eqj_pkg::ST_SCAN;
               end
            end
         end
         eqj_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = eqj_pkg::ST_FINISH;
            end
         end
         eqj_pkg::ST_FINISH: begin
            if (!is_probe || !pend_valid_ff || !out_full) begin
               state_in = eqj_pkg::ST_IDLE;
            end
         end
         default: state_in = eqj_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop       = 1'b0;
      out_push      = 1'b0;
      out_data      = '0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      cur_in        = cur_ff;
      rows_in       = rows_ff;
      distinct_in   = distinct_ff;
      probes_in     = probes_ff;
      dropped_in    = dropped_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      seen_in       = seen_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      unique case (state_ff)
         eqj_pkg::ST_IDLE: begin
            if (!cmd_empty) begin
               unique case (cmd_data.op)
                  eqj_pkg::OP_CLEAR: begin
                     cmd_pop     = 1'b1;
                     rows_in     = '0;
                     distinct_in = '0;
                     probes_in   = '0;
                     dropped_in  = 1'b0;
                  end
                  eqj_pkg::OP_REPORT: begin
                     if (!out_full) begin
                        cmd_pop                = 1'b1;
                        out_push               = 1'b1;
                        out_data.is_report     = 1'b1;
                        out_data.last          = 1'b1;
                        out_data.right_rows    = rows_ff;
                        out_data.distinct_keys = distinct_ff;
                        out_data.probe_count   = probes_ff;
                        out_data.overflow      = dropped_ff;
                     end
                  end
                  eqj_pkg::OP_BUILD: begin
                     cmd_pop = 1'b1;
                     if (rows_ff >= ROWS_MAX) begin
                        dropped_in = 1'b1;
                     end else begin
                        cur_in        = cmd_data;
                        rd_idx_in     = '0;
                        cmp_valid_in  = 1'b0;
                        seen_in       = 1'b0;
                        pend_valid_in = 1'b0;
                     end
                  end
                  default: begin
                     cmd_pop       = 1'b1;
                     cur_in        = cmd_data;
                     rd_idx_in     = '0;
                     cmp_valid_in  = 1'b0;
                     seen_in       = 1'b0;
                     pend_valid_in = 1'b0;
                     if (probes_ff != PROBE_SAT) begin
                        probes_in = probes_ff + 1'b1;
                     end
                  end
               endcase
            end
         end
         eqj_pkg::ST_SCAN: begin
            if (advance) begin
               if (hit) begin
                  if (!is_probe) begin
                     seen_in = 1'b1;
                  end else begin
                     // The previous pair is known not to be the last one now.
                     if (pend_valid_ff) begin
                        out_push             = 1'b1;
                        out_data.match_left  = cur_ff.left_index;
                        out_data.match_right = eqj_pkg::RIGHT_W'(pend_idx_ff);
                     end
                     pend_valid_in = 1'b1;
                     pend_idx_in   = cmp_idx_ff;
                  end
               end
               mem_re       = launch;
               cmp_valid_in = launch;
               cmp_idx_in   = rd_idx_ff[AW-1:0];
               if (launch) begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
         end
         eqj_pkg::ST_FINISH: begin
            if (!is_probe) begin
               mem_we  = 1'b1;
               rows_in = rows_ff + 1'b1;
               if (cur_ff.has_key && !seen_ff) begin
                  distinct_in = distinct_ff + 1'b1;
               end
            end else if (pend_valid_ff && !out_full) begin
               out_push             = 1'b1;
               out_data.match_left  = cur_ff.left_index;
               out_data.match_right = eqj_pkg::RIGHT_W'(pend_idx_ff);
               out_data.last        = 1'b1;
               pend_valid_in        = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= eqj_pkg::ST_IDLE;
         rows_ff       <= '0;
         distinct_ff   <= '0;
         probes_ff     <= '0;
         dropped_ff    <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rows_ff       <= rows_in;
         distinct_ff   <= distinct_in;
         probes_ff     <= probes_in;
         dropped_ff    <= dropped_in;
         cmp_valid_ff  <= cmp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      seen_ff     <= seen_in;
      pend_idx_ff <= pend_idx_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[rows_ff[AW-1:0]] <= wentry;
      end
      if (mem_re) begin
         rdata_ff <= mem[rd_idx_ff[AW-1:0]];
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result beat pushed into a full queue");

   a_rows_bound: assert property (@(posedge clock) disable iff (reset)
      rows_ff <= ROWS_MAX)
      else $error("row count beyond table size");

   a_distinct_bound: assert property (@(posedge clock) disable iff (reset)
      distinct_ff <= rows_ff)
      else $error("more distinct keys than rows");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == eqj_pkg::ST_SCAN && cmp_valid_ff) |-> (CW'(cmp_idx_ff) < rows_ff))
      else $error("compare of a row beyond the table");

endmodule

>>> rtl/equi_join_match_engine.sv
`timescale 1ns / 1ps
// Sequence: a build or probe holds the back end through a scan of the stored rows and a
// finish step; clear and report are done in idle, with a queue on each side of the back end.
// Throughput: the back end reads the single-port key table one row per cycle, unless a
// probe waits on a full result queue; a new build or probe starts only once the last is done.
// Reset: synchronous and active high; it empties both queues and zeroes all counters.
// The key table itself is not cleared; only rows below the row count are ever read.

module equi_join_match_engine #(
   parameter int RIGHT_ROWS = eqj_pkg::RIGHT_ROWS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  eqj_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output eqj_pkg::rsp_type rsp_data
);

   eqj_pkg::cmd_type cmd_data;
   logic             cmd_empty, cmd_pop;
   eqj_pkg::rsp_type out_data;
   logic             out_push, out_full;

   eqj_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty)
   );

   eqj_back #(
      .RIGHT_ROWS (RIGHT_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (cmd_data),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .out_data  (out_data),
      .out_push  (out_push),
      .out_full  (out_full)
   );

   eqj_fifo #(
      .DEPTH     (eqj_pkg::RSP_DEPTH),
      .DATA_TYPE (eqj_pkg::rsp_type)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule
